// ===== design/tcp_connection_tracking_table_assert.svh =====
// Assertion macros for the connection tracking table.
`ifndef TCP_CONNECTION_TRACKING_TABLE_ASSERT_SVH
`define TCP_CONNECTION_TRACKING_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define TCT_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCT_ASSERT_IMPL(label, clk, rst, prop, msg)
`define TCT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== design/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants of the connection tracking table.
// ----------------------------------------------------------------------------
package tct_pkg;
  localparam int TableDepthDefault = 1024;

  localparam logic [2:0] OP_SYN    = 3'd0;
  localparam logic [2:0] OP_SYNACK = 3'd1;
  localparam logic [2:0] OP_ACK    = 3'd2;
  localparam logic [2:0] OP_FIN    = 3'd3;
  localparam logic [2:0] OP_DATA   = 3'd4;

  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_INIT   = 3'd1;
  localparam logic [2:0] ST_ACKW   = 3'd2;
  localparam logic [2:0] ST_EST    = 3'd3;
  localparam logic [2:0] ST_FIN1   = 3'd4;
  localparam logic [2:0] ST_FIN2   = 3'd5;
  localparam logic [2:0] ST_CLOSED = 3'd6;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_PROTO  = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol_id;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [9:0]  entry_index;
    logic [2:0]  conn_state;
    logic        table_full;
    logic        session_closed;
    logic [31:0] control_count;
    logic [31:0] data_count;
    logic [31:0] client_sent_count;
    logic [31:0] server_sent_count;
    logic [31:0] retrans_count;
  } out_word_t;

  // tuple entry: active bit, client ip, server ip, client port, server port, protocol
  typedef struct packed {
    logic        act;
    logic [31:0] cip;
    logic [31:0] sip;
    logic [15:0] cport;
    logic [15:0] sport;
    logic [7:0]  proto;
  } tuple_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [31:0] ctrl;
    logic [31:0] data;
    logic [31:0] cli;
    logic [31:0] srv;
    logic [31:0] retr;
  } counters_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction
endpackage

// ===== design/tct_if.sv =====
// ----------------------------------------------------------------------------
// tct_stream_if / tct_cfg_if
// Valid/ready channels of the connection tracking table.
// ----------------------------------------------------------------------------
interface tct_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tct_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== design/tct_ram.sv =====
// ----------------------------------------------------------------------------
// tct_ram
// Single port RAM with registered read.
// ----------------------------------------------------------------------------
module tct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/tcp_connection_tracking_table.sv =====
// One packet event at a time: a lookup walks slots 0 up to the high-water mark,
// one tuple RAM read per cycle, and records the first match and the first free
// slot in the same sweep. Then one counter RAM read, an update step and a
// write-back follow; a match ends the sweep early. Active bits live in the
// tuple RAM; slots at or above the mark are never read, so reset only
// clears the mark. The result sits in an output register so the next event is
// accepted while it waits; that event holds before its update until the word
// is taken.
// ----------------------------------------------------------------------------
// tcp_connection_tracking_table
// Stateful connection table with per-entry TCP state and counters.
// ----------------------------------------------------------------------------
`include "tcp_connection_tracking_table_assert.svh"
module tcp_connection_tracking_table #(
  parameter int TABLE_DEPTH = tct_pkg::TableDepthDefault
) (
  input  logic clk,
  input  logic rst,
  tct_cfg_if.sink    cfg,
  tct_stream_if.sink in_ch,
  tct_stream_if.source out_ch
);
  import tct_pkg::*;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int HW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CREAD = 3'd2;
  localparam logic [2:0] S_CWAIT = 3'd3;
  localparam logic [2:0] S_UPD = 3'd4;

  logic [2:0] state;
  logic       tracking_enable;
  logic [7:0] tcp_protocol_number;
  logic [HW-1:0] high_water;
  logic [HW-1:0] scan_idx;
  logic       scan_rd;       // tuple read issued last cycle
  logic [AW-1:0] rd_idx;
  logic       found, free_found;
  logic [AW-1:0] found_idx, free_idx;
  in_word_t   item;
  logic       out_valid;
  out_word_t  out_word;

  logic       t_we, c_we;
  logic [AW-1:0] t_addr, c_addr;
  tuple_t     t_wdata, t_rdata;
  counters_t  c_wdata, c_rdata, c_new;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enable <= 1'b1;
      tcp_protocol_number <= 8'd6;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ENABLE: tracking_enable <= cfg.wdata[0];
        REG_PROTO:  tcp_protocol_number <= cfg.wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_word;

  // match either direction on the tuple read last cycle
  logic t_match;
  assign t_match =
    (t_rdata.cip == item.source_ip && t_rdata.sip == item.dest_ip &&
     t_rdata.cport == item.source_port && t_rdata.sport == item.dst_port) ||
    (t_rdata.sip == item.source_ip && t_rdata.cip == item.dest_ip &&
     t_rdata.sport == item.source_port && t_rdata.cport == item.dst_port);

  // decision after scan
  logic alloc, mark_grow, full_drop;
  logic [AW-1:0] slot;
  always_comb begin
    alloc = 1'b0;
    mark_grow = 1'b0;
    full_drop = 1'b0;
    slot = found_idx;
    if (!found && item.opcode == OP_SYN && tracking_enable) begin
      if (free_found) begin
        alloc = 1'b1;
        slot = free_idx;
      end else if (high_water < HW'(TABLE_DEPTH)) begin
        alloc = 1'b1;
        mark_grow = 1'b1;
        slot = high_water[AW-1:0];
      end else begin
        full_drop = 1'b1;
      end
    end
  end

  logic cli_dir, srv_dir, closing;
  always_comb begin
    c_new = c_rdata;
    cli_dir = item.source_ip == t_rdata.cip;
    srv_dir = !cli_dir && item.source_ip == t_rdata.sip;
    closing = 1'b0;
    if (alloc) begin
      c_new = '0;
      c_new.state = (item.protocol_id == tcp_protocol_number) ? ST_INIT : ST_NONE;
      c_new.ctrl = 32'd1;
      c_new.cli = 32'd1;
    end else begin
      unique case (item.opcode)
        OP_SYN: begin
          if (tracking_enable) begin
            c_new.retr = sat_inc(c_rdata.retr);
            c_new.ctrl = sat_inc(c_rdata.ctrl);
          end
        end
        OP_SYNACK, OP_ACK, OP_FIN, OP_DATA: begin
          if (item.opcode == OP_DATA) c_new.data = sat_inc(c_rdata.data);
          else c_new.ctrl = sat_inc(c_rdata.ctrl);
          if (cli_dir) c_new.cli = sat_inc(c_rdata.cli);
          if (srv_dir) c_new.srv = sat_inc(c_rdata.srv);
          if (item.opcode == OP_SYNACK && c_rdata.state == ST_INIT) begin
            c_new.state = ST_ACKW;
          end
          if (item.opcode == OP_ACK) begin
            if (c_rdata.state == ST_ACKW) begin
              c_new.state = ST_EST;
            end else if (c_rdata.state == ST_FIN2) begin
              c_new.state = ST_CLOSED;
              closing = 1'b1;
            end
          end
          if (item.opcode == OP_FIN) begin
            c_new.state = (c_rdata.state == ST_FIN1) ? ST_FIN2 : ST_FIN1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    t_we = 1'b0;
    c_we = 1'b0;
    t_addr = scan_idx[AW-1:0];
    c_addr = slot;
    // a closing entry keeps its tuple and drops its active bit
    t_wdata = t_rdata;
    t_wdata.act = 1'b0;
    if (alloc) begin
      t_wdata = '{act: 1'b1, cip: item.source_ip, sip: item.dest_ip,
                  cport: item.source_port, sport: item.dst_port,
                  proto: item.protocol_id};
    end
    c_wdata = c_new;
    if (state == S_CREAD || state == S_CWAIT) begin
      t_addr = slot;
    end else if (state == S_UPD) begin
      t_addr = slot;
      t_we = alloc || (found && closing);
      c_we = found || alloc;
    end
  end

  tct_ram #(.Width($bits(tuple_t)), .Depth(TABLE_DEPTH)) u_tuple (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata));
  tct_ram #(.Width($bits(counters_t)), .Depth(TABLE_DEPTH)) u_cnt (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      high_water <= '0;
      out_valid <= 1'b0;
      scan_rd <= 1'b0;
      found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (state == S_UPD) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item <= in_ch.data;
            scan_idx <= '0;
            scan_rd <= 1'b0;
            found <= 1'b0;
            free_found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // check the word read last cycle, issue the next read
          if (scan_rd) begin
            if (t_rdata.act) begin
              if (t_match && !found) begin
                found <= 1'b1;
                found_idx <= rd_idx;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx <= rd_idx;
            end
          end
          if (scan_idx < high_water && !(scan_rd && t_rdata.act && t_match)
              && !found) begin
            rd_idx <= scan_idx[AW-1:0];
            scan_rd <= 1'b1;
            scan_idx <= scan_idx + HW'(1);
          end else begin
            scan_rd <= 1'b0;
            state <= S_CREAD;
          end
        end
        S_CREAD: state <= S_CWAIT;
        S_CWAIT: begin
          // hold until the previous result word is taken
          if (!out_valid || out_ch.ready) state <= S_UPD;
        end
        S_UPD: begin
          if (mark_grow) high_water <= high_water + HW'(1);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      out_word.hit <= found;
      out_word.table_full <= full_drop;
      out_word.session_closed <= found && closing;
      if (found || alloc) begin
        out_word.entry_index <= 10'(slot);
        out_word.conn_state <= c_new.state;
        out_word.control_count <= c_new.ctrl;
        out_word.data_count <= c_new.data;
        out_word.client_sent_count <= c_new.cli;
        out_word.server_sent_count <= c_new.srv;
        out_word.retrans_count <= c_new.retr;
      end else begin
        out_word.entry_index <= '0;
        out_word.conn_state <= ST_NONE;
        out_word.control_count <= '0;
        out_word.data_count <= '0;
        out_word.client_sent_count <= '0;
        out_word.server_sent_count <= '0;
        out_word.retrans_count <= '0;
      end
    end
  end

  `TCT_ASSERT_IMPL(a_mark_bound, clk, rst, high_water <= HW'(TABLE_DEPTH), "mark past depth")
  `TCT_ASSERT_IMPL(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> !in_ch.ready, "ready while busy")
  `TCT_ASSERT_IMPL(a_full_no_hit, clk, rst, (out_valid && out_word.table_full) |-> !out_word.hit, "full with hit")
  `TCT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !out_valid), "reset not idle")
endmodule
